FILE: hdl/tcip_pkg.sv
// Shared types and constants of the triangle cluster index packer.
package tcip_pkg;

    localparam int VERTEX_W      = 31;
    localparam int CORNERS       = 3;
    localparam int REF_WINDOW    = 30;
    localparam int DELTA_W       = 5;
    localparam int SLOT_W        = 8;
    localparam int TRI_OUT_W     = 7;
    localparam int MASK_W        = 3;
    localparam int SHIFT_W       = 2;

    localparam int MAX_TRIANGLES_DEF = 128;
    localparam int MAX_VERTICES_DEF  = 256;
    localparam int HISTORY_DEPTH_DEF = 32;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 144;

    // per-cycle command to every history cell
    typedef struct packed {
        logic               cmp_en;  // latch the compare against the probe corners
        logic [SHIFT_W-1:0] shift;   // number of new vertices pushed in this cycle
    } cell_ctrl_t;

endpackage

FILE: hdl/tcip_cell.sv
// One history cell: holds one recent cluster vertex and compares it with three corners.
module tcip_cell import tcip_pkg::*; (
    input  logic                aclk,
    input  cell_ctrl_t          ctrl,
    input  logic [VERTEX_W-1:0] prev_i  [CORNERS],  // value one, two, three places upstream
    input  logic [VERTEX_W-1:0] probe_i [CORNERS],
    output logic [VERTEX_W-1:0] value_o,
    output logic [CORNERS-1:0]  match_o
);

    logic [VERTEX_W-1:0] value_reg, value_next;
    logic [CORNERS-1:0]  match_reg, match_next;

    always_comb begin
        if (ctrl.shift == '0) begin
            value_next = value_reg;
        end else begin
            value_next = prev_i[ctrl.shift - SHIFT_W'(1)];
        end
        match_next = match_reg;
        if (ctrl.cmp_en) begin
            for (int c = 0; c < CORNERS; c++) begin
                match_next[c] = (value_reg == probe_i[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign value_o = value_reg;
    assign match_o = match_reg;

endmodule

FILE: hdl/triangle_cluster_index_packer.sv
// Top level of the triangle cluster index packer: control, encoder and history chain.
//
// Triangles arrive as three 31-bit mesh vertex indices and leave one result each,
// in order. An accepted triangle waits in an input register, then its corners are
// compared against every cell of the history chain (the last HISTORY_DEPTH cluster
// vertices, newest in cell 0). Once the output register is free, the nearest hits
// within the last 30 vertices of the open cluster are encoded (none while
// compress_mode is 0), the triangle is rotated so that references come first, the
// new corners are pushed into the chain and the result is loaded into the output
// register. The next triangle may wait in the input register meanwhile, but its
// compare has to see the chain after the previous triangle's push. A waiting
// result holds the encode stage and so the compare. compress_mode resets to 1 and
// is to be written only while the block is idle; the block does not enforce this.
module triangle_cluster_index_packer import tcip_pkg::*; #(
    parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
    parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // vertex_a, vertex_b, vertex_c; three zero bits on top
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cluster_start, triangle_in_cluster, corner_0, corner_1, corner_2, new_mask,
    // slot_0, slot_1, slot_2, delta_0, delta_1, delta_2; one zero bit on top
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // compress_mode
    input  logic                  cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    localparam int TCW = $clog2(MAX_TRIANGLES + 1);
    localparam int VCW = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic               found;
        logic [DELTA_W-1:0] delta;
    } hit_t;

    // nearest hit: lowest distance wins
    function automatic hit_t find_nearest(input logic [REF_WINDOW-1:0] m);
        hit_t h;
        h = '0;
        for (int i = REF_WINDOW - 1; i >= 0; i--) begin
            if (m[i]) begin
                h.found = 1'b1;
                h.delta = DELTA_W'(i);
            end
        end
        return h;
    endfunction

    // handshake and stage control
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic m_valid_reg, m_valid_next;
    logic s_accept, a_move, out_free, b_done;

    // cluster state
    logic           compress_reg, compress_next;
    logic           open_reg, open_next;
    logic [VCW-1:0] vc_reg, vc_next;
    logic [TCW-1:0] tri_reg, tri_next;
    logic           start_now;

    // payload stages
    logic [VERTEX_W-1:0]   a_vtx_reg [CORNERS];
    logic [VERTEX_W-1:0]   b_vtx_reg [CORNERS];
    logic                  b_start_reg;
    logic [VCW-1:0]        b_vc_reg, b_vc_next;
    logic [TCW-1:0]        b_tri_reg, b_tri_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // history chain
    cell_ctrl_t          cell_ctrl;
    logic [VERTEX_W-1:0] cell_val   [HISTORY_DEPTH];
    logic [CORNERS-1:0]  cell_match [HISTORY_DEPTH];
    logic [REF_WINDOW-1:0] match_vec [CORNERS];
    logic [REF_WINDOW-1:0] window_mask;

    // encode and rotate
    hit_t                hit       [CORNERS];
    logic [CORNERS-1:0]  is_new;
    logic [SHIFT_W-1:0]  n_new;
    logic [1:0]          rot;
    logic [VERTEX_W-1:0] rot_vtx   [CORNERS];
    logic [DELTA_W-1:0]  rot_delta [CORNERS];
    logic [MASK_W-1:0]   rot_new;
    logic [SLOT_W-1:0]   rot_slot  [CORNERS];

    assign s_accept  = s_tvalid & s_tready;
    assign a_move    = a_valid_reg & ~b_valid_reg;
    assign out_free  = ~m_valid_reg | m_tready;
    assign b_done    = b_valid_reg & out_free;
    assign s_tready  = ~a_valid_reg | a_move;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign start_now = ~open_reg
                     | (tri_reg >= TCW'(MAX_TRIANGLES))
                     | (({1'b0, vc_reg} + (VCW+1)'(CORNERS)) > (VCW+1)'(MAX_VERTICES));

    assign cell_ctrl.cmp_en = a_move;
    assign cell_ctrl.shift  = b_done ? n_new : '0;

    // history chain: cell 0 is the newest vertex; the first cells take new corners
    for (genvar j = 0; j < HISTORY_DEPTH; j++) begin : g_cell
        logic [VERTEX_W-1:0] prev [CORNERS];
        for (genvar t = 0; t < CORNERS; t++) begin : g_prev
            if (j - t - 1 >= 0) begin : g_chain
                assign prev[t] = cell_val[j-t-1];
            end else begin : g_feed
                assign prev[t] = rot_vtx[CORNERS-1-j];
            end
        end
        tcip_cell u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl),
            .prev_i  (prev),
            .probe_i (a_vtx_reg),
            .value_o (cell_val[j]),
            .match_o (cell_match[j])
        );
    end

    for (genvar d = 0; d < REF_WINDOW; d++) begin : g_window
        assign window_mask[d] = compress_reg & (VCW'(d) < b_vc_reg);
        for (genvar c = 0; c < CORNERS; c++) begin : g_match
            assign match_vec[c][d] = cell_match[d][c];
        end
    end

    always_comb begin
        logic [SHIFT_W-1:0] rank;
        logic [1:0]         k;
        rank = '0;
        k    = '0;
        for (int c = 0; c < CORNERS; c++) begin
            hit[c]    = find_nearest(match_vec[c] & window_mask);
            is_new[c] = ~hit[c].found;
        end
        n_new = SHIFT_W'($countones(is_new));

        // put references ahead of new corners, keeping cyclic order
        rot = 2'd0;
        if (n_new == SHIFT_W'(1)) begin
            if (is_new[0]) begin
                rot = 2'd1;
            end else if (is_new[1]) begin
                rot = 2'd2;
            end
        end else if (n_new == SHIFT_W'(2)) begin
            if (is_new[0] && is_new[1]) begin
                rot = 2'd2;
            end else if (is_new[0] && is_new[2]) begin
                rot = 2'd1;
            end
        end

        for (int i = 0; i < CORNERS; i++) begin
            case (rot)
                2'd1:    k = (i == 2) ? 2'd0 : 2'(i + 1);
                2'd2:    k = (i == 0) ? 2'd2 : 2'(i - 1);
                default: k = 2'(i);
            endcase
            rot_vtx[i] = b_vtx_reg[k];
            rot_new[i] = is_new[k];
            if (is_new[k]) begin
                rot_delta[i] = '0;
                rot_slot[i]  = SLOT_W'(b_vc_reg + VCW'(rank));
                rank         = rank + SHIFT_W'(1);
            end else begin
                rot_delta[i] = hit[k].delta;
                rot_slot[i]  = SLOT_W'(b_vc_reg - VCW'(1) - VCW'(hit[k].delta));
            end
        end
    end

    always_comb begin
        a_valid_next  = a_valid_reg;
        b_valid_next  = b_valid_reg;
        m_valid_next  = m_valid_reg;
        compress_next = compress_reg;
        open_next     = open_reg;
        vc_next       = vc_reg;
        tri_next      = tri_reg;
        b_vc_next     = start_now ? '0 : vc_reg;
        b_tri_next    = start_now ? '0 : tri_reg;

        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end

        if (a_move) begin
            b_valid_next = 1'b1;
        end else if (b_done) begin
            b_valid_next = 1'b0;
        end

        if (b_done) begin
            m_valid_next = 1'b1;
            open_next    = 1'b1;
            vc_next      = b_vc_reg + VCW'(n_new);
            tri_next     = b_tri_reg + TCW'(1);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            compress_next = cfg_data;
        end

        m_data_next = {1'b0,
                       rot_delta[2], rot_delta[1], rot_delta[0],
                       rot_slot[2], rot_slot[1], rot_slot[0],
                       rot_new,
                       rot_vtx[2], rot_vtx[1], rot_vtx[0],
                       TRI_OUT_W'(b_tri_reg),
                       b_start_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            compress_reg <= 1'b1;
            open_reg     <= 1'b0;
            vc_reg       <= '0;
            tri_reg      <= '0;
        end else begin
            a_valid_reg  <= a_valid_next;
            b_valid_reg  <= b_valid_next;
            m_valid_reg  <= m_valid_next;
            compress_reg <= compress_next;
            open_reg     <= open_next;
            vc_reg       <= vc_next;
            tri_reg      <= tri_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int c = 0; c < CORNERS; c++) begin
                a_vtx_reg[c] <= s_tdata[c*VERTEX_W +: VERTEX_W];
            end
        end
        if (a_move) begin
            b_vtx_reg   <= a_vtx_reg;
            b_start_reg <= start_now;
            b_vc_reg    <= b_vc_next;
            b_tri_reg   <= b_tri_next;
        end
        if (b_done) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    // the open cluster never holds more vertices or triangles than allowed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vc_reg <= VCW'(MAX_VERTICES)) && (tri_reg <= TCW'(MAX_TRIANGLES)))
        else $error("cluster counters beyond their limits");

    // a triangle only enters the compare stage when the chain is settled
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_move |-> !b_valid_reg && !b_done)
        else $error("compare overlaps a chain push");

    // references always come before new corners
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (rot_new == 3'b000) || (rot_new == 3'b100) ||
                        (rot_new == 3'b110) || (rot_new == 3'b111))
        else $error("new corner ahead of a reference");

    // a stalled triangle in the encode stage stays there
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !out_free |=> b_valid_reg && $stable(b_vc_reg))
        else $error("encode stage dropped a stalled triangle");

    // a triangle that opens a cluster is its first triangle
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_start_reg |-> (b_tri_reg == '0) && (b_vc_reg == '0))
        else $error("cluster start with nonzero counts");
`endif

endmodule
